// ----- rtl/hrp_pkg.sv -----
package hrp_pkg;

  // Width of the version accumulators; values saturate at all ones.
  localparam int unsigned VERSION_WIDTH = 8;

  // Depth of the queue between the classifier and the parser core.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character constants used by the classifier and the parser.
  localparam logic [7:0] CTRL_MAX = 8'd31;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic {
    OP_DATA    = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_INDET = 2'd0,
    STATUS_GOOD  = 2'd1,
    STATUS_BAD   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    TAG_NONE   = 3'd0,
    TAG_METHOD = 3'd1,
    TAG_URI    = 3'd2,
    TAG_NAME   = 3'd3,
    TAG_VALUE  = 3'd4
  } tag_e;

  typedef enum logic [4:0] {
    ST_METHOD_START       = 5'd0,
    ST_METHOD             = 5'd1,
    ST_URI                = 5'd2,
    ST_VER_H              = 5'd3,
    ST_VER_T1             = 5'd4,
    ST_VER_T2             = 5'd5,
    ST_VER_P              = 5'd6,
    ST_VER_SLASH          = 5'd7,
    ST_MAJOR_START        = 5'd8,
    ST_MAJOR              = 5'd9,
    ST_MINOR_START        = 5'd10,
    ST_MINOR              = 5'd11,
    ST_LF1                = 5'd12,
    ST_LINE_START         = 5'd13,
    ST_LWS                = 5'd14,
    ST_NAME               = 5'd15,
    ST_SPACE_BEFORE_VALUE = 5'd16,
    ST_VALUE              = 5'd17,
    ST_LF2                = 5'd18,
    ST_LF3                = 5'd19
  } parse_state_e;

  // Character classes computed once in the front end.
  typedef struct packed {
    logic token;
    logic ctrl;
    logic dec;
    logic sp;
    logic ht;
    logic cr;
    logic lf;
    logic colon;
    logic dot;
    logic slash;
    logic h;
    logic t;
    logic p;
  } char_class_t;

  typedef struct packed {
    logic        restart;
    logic [7:0]  data;
    char_class_t cls;
  } queue_entry_t;

  typedef struct packed {
    status_e    status;
    tag_e       tag;
    logic       hb;
    logic [7:0] data;
    logic [7:0] major;
    logic [7:0] minor;
  } result_t;

  function automatic logic is_control(logic [7:0] c);
    return (c <= CTRL_MAX) || (c == CH_DEL);
  endfunction

  // HTTP separator characters, including space and horizontal tab.
  function automatic logic is_separator(logic [7:0] c);
    logic sep;
    case (c) inside
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic is_token(logic [7:0] c);
    return (c <= CH_DEL) && !is_control(c) && !is_separator(c);
  endfunction

  // acc * 10 + digit, saturating at all ones.
  function automatic logic [VERSION_WIDTH-1:0] acc_digit(logic [VERSION_WIDTH-1:0] acc,
                                                          logic [7:0] c);
    logic [VERSION_WIDTH+3:0] wide;
    logic [VERSION_WIDTH+3:0] sum;
    logic [7:0]               diff;
    logic [VERSION_WIDTH-1:0] res;
    wide = {4'd0, acc};
    diff = c - CH_ZERO;
    sum  = (wide << 3) + (wide << 1) + {{VERSION_WIDTH{1'b0}}, diff[3:0]};
    if (sum[VERSION_WIDTH+3:VERSION_WIDTH] != 4'd0) begin
      res = '1;
    end else begin
      res = sum[VERSION_WIDTH-1:0];
    end
    return res;
  endfunction

  // Low eight bits of an accumulator, zero extended when it is narrower.
  function automatic logic [7:0] report_version(logic [VERSION_WIDTH-1:0] acc);
    logic [VERSION_WIDTH+7:0] ext;
    ext = {8'd0, acc};
    return ext[7:0];
  endfunction

endpackage

// ----- rtl/hrp_in_if.sv -----
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

// ----- rtl/hrp_out_if.sv -----
interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] field_tag;
  logic       header_begin;
  logic [7:0] byte_out;
  logic [7:0] version_major;
  logic [7:0] version_minor;

  modport source (output valid, output status, output field_tag, output header_begin,
                  output byte_out, output version_major, output version_minor,
                  input ready);
  modport sink (input valid, input status, input field_tag, input header_begin,
                input byte_out, input version_major, input version_minor,
                output ready);
endinterface

// ----- rtl/hrp_front.sv -----
module hrp_front (
  hrp_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output hrp_pkg::queue_entry_t entry_o
);

  logic [7:0] c;

  // Accept a transaction whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign c          = in_i.data_byte;

  // Classify the byte so the parser core only selects on flags.
  always_comb begin
    entry_o.restart   = (in_i.operation == hrp_pkg::OP_RESTART);
    entry_o.data      = c;
    entry_o.cls.token = hrp_pkg::is_token(c);
    entry_o.cls.ctrl  = hrp_pkg::is_control(c);
    entry_o.cls.dec   = (c >= hrp_pkg::CH_ZERO) && (c <= hrp_pkg::CH_NINE);
    entry_o.cls.sp    = (c == hrp_pkg::CH_SP);
    entry_o.cls.ht    = (c == hrp_pkg::CH_HT);
    entry_o.cls.cr    = (c == hrp_pkg::CH_CR);
    entry_o.cls.lf    = (c == hrp_pkg::CH_LF);
    entry_o.cls.colon = (c == hrp_pkg::CH_COLON);
    entry_o.cls.dot   = (c == hrp_pkg::CH_DOT);
    entry_o.cls.slash = (c == hrp_pkg::CH_SLASH);
    entry_o.cls.h     = (c == hrp_pkg::CH_H);
    entry_o.cls.t     = (c == hrp_pkg::CH_T);
    entry_o.cls.p     = (c == hrp_pkg::CH_P);
  end

endmodule

// ----- rtl/hrp_queue.sv -----
module hrp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hrp_pkg::queue_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output hrp_pkg::queue_entry_t entry_o
);

  hrp_pkg::queue_entry_t           mem_q [hrp_pkg::QUEUE_DEPTH];
  logic [hrp_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [hrp_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [hrp_pkg::QCNT_W-1:0]      count_q, count_d;

  localparam logic [hrp_pkg::QPTR_W-1:0] LastPtr = hrp_pkg::QPTR_W'(hrp_pkg::QUEUE_DEPTH - 1);
  localparam logic [hrp_pkg::QCNT_W-1:0] FullCnt = hrp_pkg::QCNT_W'(hrp_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/hrp_back.sv -----
module hrp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  hrp_pkg::queue_entry_t q_entry_i,
  output logic                  pop_o,
  hrp_out_if.source             out_o
);

  hrp_pkg::parse_state_e            st_q, st_d;
  logic                             hs_q, hs_d;
  logic [hrp_pkg::VERSION_WIDTH-1:0] maj_q, maj_d;
  logic [hrp_pkg::VERSION_WIDTH-1:0] min_q, min_d;
  hrp_pkg::result_t                 res_q, res_d;
  logic                             out_valid_q;
  hrp_pkg::char_class_t             cls;
  logic [7:0]                       c;

  assign cls   = q_entry_i.cls;
  assign c     = q_entry_i.data;
  assign pop_o = q_valid_i && (!out_valid_q || out_o.ready);

  // Next parser state and accumulators; a bad byte changes nothing.
  always_comb begin
    st_d  = st_q;
    hs_d  = hs_q;
    maj_d = maj_q;
    min_d = min_q;
    if (q_entry_i.restart) begin
      st_d  = hrp_pkg::ST_METHOD_START;
      hs_d  = 1'b0;
      maj_d = '0;
      min_d = '0;
    end else begin
      unique case (st_q)
        hrp_pkg::ST_METHOD_START: if (cls.token) st_d = hrp_pkg::ST_METHOD;
        hrp_pkg::ST_METHOD:       if (cls.sp) st_d = hrp_pkg::ST_URI;
        hrp_pkg::ST_URI:          if (cls.sp) st_d = hrp_pkg::ST_VER_H;
        hrp_pkg::ST_VER_H:        if (cls.h) st_d = hrp_pkg::ST_VER_T1;
        hrp_pkg::ST_VER_T1:       if (cls.t) st_d = hrp_pkg::ST_VER_T2;
        hrp_pkg::ST_VER_T2:       if (cls.t) st_d = hrp_pkg::ST_VER_P;
        hrp_pkg::ST_VER_P:        if (cls.p) st_d = hrp_pkg::ST_VER_SLASH;
        hrp_pkg::ST_VER_SLASH: begin
          if (cls.slash) begin
            maj_d = '0;
            min_d = '0;
            st_d  = hrp_pkg::ST_MAJOR_START;
          end
        end
        hrp_pkg::ST_MAJOR_START: begin
          if (cls.dec) begin
            maj_d = hrp_pkg::acc_digit(maj_q, c);
            st_d  = hrp_pkg::ST_MAJOR;
          end
        end
        hrp_pkg::ST_MAJOR: begin
          if (cls.dot) st_d = hrp_pkg::ST_MINOR_START;
          else if (cls.dec) maj_d = hrp_pkg::acc_digit(maj_q, c);
        end
        hrp_pkg::ST_MINOR_START: begin
          if (cls.dec) begin
            min_d = hrp_pkg::acc_digit(min_q, c);
            st_d  = hrp_pkg::ST_MINOR;
          end
        end
        hrp_pkg::ST_MINOR: begin
          if (cls.cr) st_d = hrp_pkg::ST_LF1;
          else if (cls.dec) min_d = hrp_pkg::acc_digit(min_q, c);
        end
        hrp_pkg::ST_LF1: if (cls.lf) st_d = hrp_pkg::ST_LINE_START;
        hrp_pkg::ST_LINE_START: begin
          if (cls.cr) begin
            st_d = hrp_pkg::ST_LF3;
          end else if (hs_q && (cls.sp || cls.ht)) begin
            st_d = hrp_pkg::ST_LWS;
          end else if (cls.token) begin
            hs_d = 1'b1;
            st_d = hrp_pkg::ST_NAME;
          end
        end
        hrp_pkg::ST_LWS: begin
          if (cls.cr) st_d = hrp_pkg::ST_LF2;
          else if (!cls.sp && !cls.ht && !cls.ctrl) st_d = hrp_pkg::ST_VALUE;
        end
        hrp_pkg::ST_NAME:               if (cls.colon) st_d = hrp_pkg::ST_SPACE_BEFORE_VALUE;
        hrp_pkg::ST_SPACE_BEFORE_VALUE: if (cls.sp) st_d = hrp_pkg::ST_VALUE;
        hrp_pkg::ST_VALUE:              if (cls.cr) st_d = hrp_pkg::ST_LF2;
        hrp_pkg::ST_LF2:                if (cls.lf) st_d = hrp_pkg::ST_LINE_START;
        hrp_pkg::ST_LF3:                st_d = st_q;
        default:                        st_d = st_q;
      endcase
    end
  end

  // Status, field tag and header flag for the current byte.
  always_comb begin
    res_d.status = hrp_pkg::STATUS_INDET;
    res_d.tag    = hrp_pkg::TAG_NONE;
    res_d.hb     = 1'b0;
    res_d.data   = q_entry_i.restart ? 8'd0 : c;
    res_d.major  = hrp_pkg::report_version(maj_d);
    res_d.minor  = hrp_pkg::report_version(min_d);
    if (!q_entry_i.restart) begin
      unique case (st_q)
        hrp_pkg::ST_METHOD_START: begin
          if (cls.token) res_d.tag = hrp_pkg::TAG_METHOD;
          else res_d.status = hrp_pkg::STATUS_BAD;
        end
        hrp_pkg::ST_METHOD: begin
          if (cls.sp) res_d.tag = hrp_pkg::TAG_NONE;
          else if (cls.token) res_d.tag = hrp_pkg::TAG_METHOD;
          else res_d.status = hrp_pkg::STATUS_BAD;
        end
        hrp_pkg::ST_URI: begin
          if (cls.sp) res_d.tag = hrp_pkg::TAG_NONE;
          else if (cls.ctrl) res_d.status = hrp_pkg::STATUS_BAD;
          else res_d.tag = hrp_pkg::TAG_URI;
        end
        hrp_pkg::ST_VER_H:       if (!cls.h) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_VER_T1:      if (!cls.t) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_VER_T2:      if (!cls.t) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_VER_P:       if (!cls.p) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_VER_SLASH:   if (!cls.slash) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_MAJOR_START: if (!cls.dec) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_MAJOR:       if (!cls.dot && !cls.dec) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_MINOR_START: if (!cls.dec) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_MINOR:       if (!cls.cr && !cls.dec) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_LF1:         if (!cls.lf) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_LINE_START: begin
          if (cls.cr || (hs_q && (cls.sp || cls.ht))) begin
            res_d.tag = hrp_pkg::TAG_NONE;
          end else if (!cls.token) begin
            res_d.status = hrp_pkg::STATUS_BAD;
          end else begin
            res_d.tag = hrp_pkg::TAG_NAME;
            res_d.hb  = 1'b1;
          end
        end
        hrp_pkg::ST_LWS: begin
          if (cls.cr || cls.sp || cls.ht) res_d.tag = hrp_pkg::TAG_NONE;
          else if (cls.ctrl) res_d.status = hrp_pkg::STATUS_BAD;
          else res_d.tag = hrp_pkg::TAG_VALUE;
        end
        hrp_pkg::ST_NAME: begin
          if (cls.colon) res_d.tag = hrp_pkg::TAG_NONE;
          else if (cls.token) res_d.tag = hrp_pkg::TAG_NAME;
          else res_d.status = hrp_pkg::STATUS_BAD;
        end
        hrp_pkg::ST_SPACE_BEFORE_VALUE: if (!cls.sp) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_VALUE: begin
          if (cls.cr) res_d.tag = hrp_pkg::TAG_NONE;
          else if (cls.ctrl) res_d.status = hrp_pkg::STATUS_BAD;
          else res_d.tag = hrp_pkg::TAG_VALUE;
        end
        hrp_pkg::ST_LF2: if (!cls.lf) res_d.status = hrp_pkg::STATUS_BAD;
        hrp_pkg::ST_LF3: begin
          res_d.status = cls.lf ? hrp_pkg::STATUS_GOOD : hrp_pkg::STATUS_BAD;
        end
        default: res_d.status = hrp_pkg::STATUS_BAD;
      endcase
    end
  end

  // Parser state advances once per queued transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= hrp_pkg::ST_METHOD_START;
      hs_q        <= 1'b0;
      maj_q       <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        st_q        <= st_d;
        hs_q        <= hs_d;
        maj_q       <= maj_d;
        min_q       <= min_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register holds until the downstream side takes it.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.field_tag     = res_q.tag;
  assign out_o.header_begin  = res_q.hb;
  assign out_o.byte_out      = res_q.data;
  assign out_o.version_major = res_q.major;
  assign out_o.version_minor = res_q.minor;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && q_entry_i.restart |=> st_q == hrp_pkg::ST_METHOD_START && !hs_q &&
                                   maj_q == '0 && min_q == '0)
    else $error("restart did not return the parser to method start");

  a_bad_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && res_d.status == hrp_pkg::STATUS_BAD |=>
      $stable(st_q) && $stable(hs_q) && $stable(maj_q) && $stable(min_q))
    else $error("bad byte changed the parser state");

  a_header_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && res_d.hb |=> hs_q && st_q == hrp_pkg::ST_NAME)
    else $error("header start did not enter the header name");

  a_good_in_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == hrp_pkg::STATUS_GOOD |-> st_q == hrp_pkg::ST_LF3)
    else $error("good status outside the final line feed check");

endmodule

// ----- rtl/http_request_head_parser_unit.sv -----
// HTTP/1.x request head parser. Each input transaction carries one request byte
// (or a restart), and each produces exactly one result transaction with a
// status, a field tag, a header start flag, the byte itself and the running
// major and minor version values. The block takes one byte per clock when the
// result side keeps up: a classifier tags each byte's character class in the
// same cycle it is accepted, a two-entry queue decouples it from the parser
// state machine, and the state machine updates its state and fills the output
// register once per byte. A result is valid after its byte passes the queue
// and the output register; the per-byte state update sets the one byte per
// clock rate. A restart transaction returns the parser to the method start.
module http_request_head_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrp_in_if.sink     in_i,
  hrp_out_if.source  out_o
);

  logic                  push;
  logic                  full;
  logic                  q_valid;
  logic                  pop;
  hrp_pkg::queue_entry_t push_entry;
  hrp_pkg::queue_entry_t pop_entry;

  // Front end: accept and classify bytes.
  hrp_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Queue between classifier and parser core.
  hrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  // Back end: parser state machine and result register.
  hrp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (pop_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
